### rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Beat payloads, operation codes and the entry format of the byte queue.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam int unsigned LEN_W   = 6;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned PEND_W  = 7;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned QBYTES  = 4;
	localparam int unsigned NB_W    = 3;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        symbol;
		logic [WORD_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [8*QBYTES-1:0] data;
		logic [NB_W-1:0]     nbytes;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} qpush_t;

	typedef struct packed {
		logic    valid;
		logic    full;
		qentry_t entry;
	} qstat_t;

endpackage

### rtl/core/hcbp_stream_if.sv
// ----------------------------------------------------------------------------
// hcbp_stream_if: valid/ready channel
// Carries one beat of the payload type given at instantiation.
// ----------------------------------------------------------------------------
interface hcbp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front: item intake, code table and bit accumulator
// Loads the table, looks up codes, packs bits, pushes whole and flush bytes.
// ----------------------------------------------------------------------------
module hcbp_front
	import hcbp_pkg::*;
#(
	parameter int unsigned MAX_CODE_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	hcbp_stream_if.sink        item,
	input  logic               q_full,
	output qpush_t             push
);
	localparam int unsigned CODE_W = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
	localparam int unsigned ACC_W  = CODE_W + PEND_W;
	localparam int unsigned ENT_W  = CODE_W + LEN_W;

	logic [ENT_W-1:0]  mem [256];
	logic [ENT_W-1:0]  rd_s1;
	logic              valid_s1;
	logic              fin_s1;
	logic [PEND_W-1:0] pend_bits_q;
	logic [CNT_W-1:0]  pend_cnt_q;

	item_t             it;
	logic              accept;
	logic [LEN_W-1:0]  clen;
	logic [WORD_W:0]   mask;
	logic [WORD_W-1:0] masked;
	logic [LEN_W-1:0]  len;
	logic [CODE_W-1:0] word;
	logic [ACC_W-1:0]  acc;
	logic [LEN_W-1:0]  total;
	logic [NB_W-1:0]   nbytes;
	logic [CNT_W-1:0]  rem;
	logic [31:0]       em;
	logic [31:0]       aligned;
	logic [14:0]       padded;
	logic              need_push;
	logic              adv;

	assign it     = item.data;
	assign accept = item.valid && item.ready;

	assign clen   = (it.code_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : it.code_len;
	assign mask   = ((WORD_W+1)'(1) << clen) - (WORD_W+1)'(1);
	assign masked = it.code_bits & mask[WORD_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && it.op == OP_LOAD) begin
			mem[it.symbol] <= {clen, masked[CODE_W-1:0]};
		end
		if (accept && it.op == OP_ENCODE) begin
			rd_s1 <= mem[it.symbol];
		end
	end

	assign len    = rd_s1[ENT_W-1:CODE_W];
	assign word   = rd_s1[CODE_W-1:0];
	assign acc    = (ACC_W'(pend_bits_q) << len) | ACC_W'(word);
	assign total  = LEN_W'(pend_cnt_q) + len;
	assign nbytes = total[LEN_W-1:3];
	assign rem    = total[2:0];
	assign em     = 32'(acc >> rem);
	assign padded = 15'(pend_bits_q) << (4'd8 - 4'(pend_cnt_q));

	always_comb begin
		unique case (nbytes)
			3'd1:    aligned = {em[7:0], 24'd0};
			3'd2:    aligned = {em[15:0], 16'd0};
			3'd3:    aligned = {em[23:0], 8'd0};
			3'd4:    aligned = em;
			default: aligned = 32'd0;
		endcase
	end

	assign need_push = fin_s1 || (nbytes != '0);
	assign adv       = valid_s1 && (!need_push || !q_full);
	assign item.ready = !valid_s1 || adv;

	always_comb begin
		push.valid = valid_s1 && need_push && !q_full;
		if (fin_s1) begin
			push.entry.data   = {padded[7:0], 5'd0, pend_cnt_q, 16'd0};
			push.entry.nbytes = NB_W'(2);
		end else begin
			push.entry.data   = aligned;
			push.entry.nbytes = nbytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fin_s1      <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (adv) begin
				if (fin_s1) begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end else begin
					pend_bits_q <= PEND_W'(acc & ACC_W'((ACC_W'(1) << rem) - ACC_W'(1)));
					pend_cnt_q  <= rem;
				end
			end
			if (accept && (it.op == OP_ENCODE || it.op == OP_FINISH)) begin
				valid_s1 <= 1'b1;
				fin_s1   <= (it.op == OP_FINISH);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue: short queue between the packer and the byte serialiser
// Holds groups of packed bytes so that either side may stall on its own.
// ----------------------------------------------------------------------------
module hcbp_queue
	import hcbp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  qpush_t push,
	input  logic   pop,
	output qstat_t stat
);
	qentry_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && stat.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !stat.full)
		else $error("Byte queue written while full.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("Byte queue count out of range.");

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (push.entry.nbytes != '0 && push.entry.nbytes <= NB_W'(QBYTES)))
		else $error("Byte queue entry with no bytes or too many.");
`endif

endmodule

### rtl/core/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back: byte serialiser
// Sends the bytes of each queue entry one beat at a time, marking the last.
// ----------------------------------------------------------------------------
module hcbp_back
	import hcbp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  qstat_t         stat,
	output logic           pop,
	hcbp_stream_if.source  result
);
	logic [8*QBYTES-1:0] data_q;
	logic [NB_W-1:0]     left_q;
	logic                valid_q;
	logic                take;
	result_t             res;

	assign take = result.valid && result.ready;
	assign pop  = stat.valid && (!valid_q || (take && left_q == NB_W'(1)));

	assign res.out_byte = data_q[8*QBYTES-1 -: 8];
	assign res.last     = (left_q == NB_W'(1));
	assign result.data  = res;
	assign result.valid = valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= stat.entry.data;
		end else if (take) begin
			data_q <= {data_q[8*QBYTES-9:0], 8'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				left_q  <= stat.entry.nbytes;
			end else if (take) begin
				left_q <= left_q - NB_W'(1);
				if (left_q == NB_W'(1)) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_left_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (left_q != '0))
		else $error("Serialiser holds a beat with no bytes left.");

	a_last_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.last && !stat.valid) |=> !valid_q)
		else $error("Serialiser kept sending after the last byte.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result.ready) |=> (valid_q && $stable(left_q)))
		else $error("Serialiser advanced while the receiver stalled.");
`endif

endmodule

### rtl/core/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top: Huffman code table and MSB-first bit packer
// Takes load, encode and finish items and sends packed bytes.
// ----------------------------------------------------------------------------
// The item channel takes one beat per cycle while the queue is not full. A
// load beat writes a code word and its length into the 256-entry table. An
// encode beat looks the symbol up and appends its code behind the pending
// bits; every whole byte leaves on the result channel, up to four per
// symbol. A finish beat sends the zero-padded leftover byte and then the
// count of its valid bits, and clears the pending bits. The final byte
// caused by an item carries last. The first byte of an item passes the
// lookup register, the byte queue and the serialiser register. Result bytes
// leave at one per cycle while the receiver is ready, so the sustained rate
// is set by the byte serialiser and by the four-entry queue of byte groups
// in front of it. When the receiver stalls, the queue fills and then the
// item channel drops ready. Reset clears the pending bits, the queue and the
// serialiser; table entries hold nothing defined until they are loaded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top
	import hcbp_pkg::*;
#(
	parameter int unsigned MAX_CODE_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	hcbp_stream_if.sink   item,
	hcbp_stream_if.source result
);
	qpush_t push;
	qstat_t stat;
	logic   pop;

	hcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (stat.full),
		.push   (push)
	);

	hcbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (stat)
	);

	hcbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.pop    (pop),
		.result (result)
	);

endmodule

### verif/tb_huffman_code_bit_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_top: self-checking bench of the bit packer
// Loads code table entries, encodes symbols and flushes the accumulator
// under random idling on both channels. Every result beat is compared
// with the bytes predicted from an independent model of the table and
// the pending bits.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_top;
	import hcbp_pkg::*;

	localparam int unsigned MAX_CODE_LEN = 32;
	localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
	localparam int unsigned RANDOM_ITEMS = 246;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		item_t beat;
		bit    drain;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic  drv_valid = 1'b0;
	item_t drv_data = '0;
	logic  rdy = 1'b0;

	hcbp_stream_if #(.payload_t(item_t)) item_ch ();
	hcbp_stream_if #(.payload_t(result_t)) result_ch ();

	assign item_ch.valid = drv_valid;
	assign item_ch.data = drv_data;
	assign result_ch.ready = rdy;

	huffman_code_bit_packer_top #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	stim_t   pending_items [$];
	result_t expected_bytes [$];

	logic [WORD_W-1:0] code_word_tbl [256];
	logic [LEN_W-1:0]  code_len_tbl [256];
	logic [PEND_W-1:0] acc_bits = '0;
	logic [CNT_W-1:0]  acc_count = '0;

	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	bit          timed_out = 1'b0;

	int send_wait = 0;
	int send_quiet = 0;
	int recv_wait = 0;
	int recv_quiet = 0;

	function automatic void predict_packed_bytes(item_t it);
		logic [63:0] acc;
		int unsigned len;
		int unsigned total;
		result_t     r;
		case (it.op)
			OP_LOAD: begin
				len = (it.code_len > LEN_LIMIT) ? LEN_LIMIT : it.code_len;
				code_word_tbl[it.symbol] = WORD_W'(it.code_bits & ((64'd1 << len) - 64'd1));
				code_len_tbl[it.symbol] = LEN_W'(len);
			end
			OP_ENCODE: begin
				len = 32'(code_len_tbl[it.symbol]);
				acc = ({57'd0, acc_bits} << len) | {32'd0, code_word_tbl[it.symbol]};
				total = acc_count + len;
				while (total >= 8) begin
					total -= 8;
					r.out_byte = acc[total +: 8];
					r.last = (total < 8);
					expected_bytes = {expected_bytes, r};
				end
				acc_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
				acc_count = CNT_W'(total);
			end
			OP_FINISH: begin
				r.out_byte = {1'b0, acc_bits} << (8 - acc_count);
				r.last = 1'b0;
				expected_bytes = {expected_bytes, r};
				r.out_byte = {5'd0, acc_count};
				r.last = 1'b1;
				expected_bytes = {expected_bytes, r};
				acc_bits = '0;
				acc_count = '0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic void add_item(logic [1:0] op, logic [7:0] sym, logic [31:0] bits,
			logic [5:0] len, bit drain);
		stim_t s;
		s.beat.op = op;
		s.beat.symbol = sym;
		s.beat.code_bits = bits;
		s.beat.code_len = len;
		s.drain = drain;
		pending_items = {pending_items, s};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_data <= '0;
			send_wait = 0;
		end else begin
			if (drv_valid && item_ch.ready) begin
				predict_packed_bytes(drv_data);
			end
			if (!drv_valid || item_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					drv_valid <= 1'b0;
				end else if (pending_items.size() == 0 ||
						(pending_items[0].drain && expected_bytes.size() != 0)) begin
					drv_valid <= 1'b0;
				end else begin
					drv_data <= pending_items[0].beat;
					pending_items.delete(0);
					drv_valid <= 1'b1;
					send_wait = draw_wait(send_quiet);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rdy <= 1'b0;
			recv_wait = 0;
		end else begin
			if (result_ch.valid && rdy) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected beat, expected none, actual byte %h last %b",
						$time, result_ch.data.out_byte, result_ch.data.last);
				end else begin
					want = expected_bytes[0];
					expected_bytes.delete(0);
					if (result_ch.data.out_byte !== want.out_byte) begin
						mismatch_count++;
						$display("%0t: out_byte expected %h, actual %h",
							$time, want.out_byte, result_ch.data.out_byte);
					end
					if (result_ch.data.last !== want.last) begin
						mismatch_count++;
						$display("%0t: last expected %b, actual %b",
							$time, want.last, result_ch.data.last);
					end
				end
				recv_wait = draw_wait(recv_quiet);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				rdy <= 1'b0;
			end else begin
				rdy <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (drv_valid && item_ch.ready) || (result_ch.valid && rdy)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				timed_out = 1'b1;
			end
		end
	end

	initial begin
		bit          is_loaded [256];
		logic [7:0]  loaded_syms [$];
		logic [7:0]  sym;
		logic [5:0]  len;
		int unsigned count;
		int unsigned pick;
		int unsigned roll;

		add_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32, 1'b0);
		add_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b0);
		add_item(OP_LOAD, 8'd1, 32'hAAAA_AAAA, 6'd0, 1'b0);
		add_item(OP_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd3, 1'b0);
		add_item(OP_LOAD, 8'd3, 32'h0000_0001, 6'd1, 1'b0);
		add_item(OP_LOAD, 8'd4, 32'h0001_2345, 6'd33, 1'b0);
		add_item(OP_LOAD, 8'd5, 32'h0000_007F, 6'd7, 1'b0);
		add_item(OP_FINISH, 8'd0, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd0, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd2, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd1, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd255, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd4, $urandom, 6'($urandom), 1'b0);
		add_item(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b0);
		add_item(OP_ENCODE, 8'd3, 32'h0000_0000, 6'd0, 1'b0);
		add_item(OP_ENCODE, 8'd2, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd2, $urandom, 6'($urandom), 1'b0);
		add_item(OP_FINISH, 8'd255, $urandom, 6'($urandom), 1'b1);
		add_item(OP_ENCODE, 8'd5, $urandom, 6'($urandom), 1'b0);
		add_item(OP_FINISH, 8'd0, $urandom, 6'($urandom), 1'b0);
		add_item(OP_LOAD, 8'd0, 32'h0000_0000, 6'd5, 1'b0);
		add_item(OP_ENCODE, 8'd0, $urandom, 6'($urandom), 1'b0);
		add_item(OP_ENCODE, 8'd3, $urandom, 6'($urandom), 1'b0);
		add_item(OP_FINISH, 8'd0, $urandom, 6'($urandom), 1'b0);

		foreach (is_loaded[i]) begin
			is_loaded[i] = 1'b0;
		end
		foreach (pending_items[i]) begin
			if (pending_items[i].beat.op == OP_LOAD && !is_loaded[pending_items[i].beat.symbol]) begin
				is_loaded[pending_items[i].beat.symbol] = 1'b1;
				loaded_syms = {loaded_syms, pending_items[i].beat.symbol};
			end
		end

		count = 0;
		while (count < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				if ($urandom_range(0, 1) == 0) begin
					sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				end else begin
					sym = 8'($urandom_range(0, 255));
				end
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					len = 6'd0;
				end else if (pick < 10) begin
					len = 6'($urandom_range(33, 63));
				end else if (pick < 25) begin
					len = 6'($urandom_range(13, 32));
				end else begin
					len = 6'($urandom_range(1, 12));
				end
				add_item(OP_LOAD, sym, $urandom, len, $urandom_range(0, 49) == 0);
				if (!is_loaded[sym]) begin
					is_loaded[sym] = 1'b1;
					loaded_syms = {loaded_syms, sym};
				end
				count++;
			end else if (roll < 22) begin
				add_item(OP_FINISH, 8'($urandom), $urandom, 6'($urandom),
					$urandom_range(0, 49) == 0);
				count++;
			end else if (roll < 26) begin
				add_item(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom), 1'b0);
			end else begin
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				add_item(OP_ENCODE, sym, $urandom, 6'($urandom), $urandom_range(0, 49) == 0);
				count++;
			end
		end
		add_item(OP_FINISH, 8'($urandom), $urandom, 6'($urandom), 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out &&
				!(pending_items.size() == 0 && !drv_valid && expected_bytes.size() == 0)) begin
			@(posedge clk);
		end
		if (!timed_out) begin
			repeat (TAIL_CYCLES) @(posedge clk);
		end

		if (!timed_out && mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
